@@ rtl/fed_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_pkg
// Shared types, constants and helpers for the stereo feedback echo.
// ----------------------------------------------------------------------------
package fed_pkg;

  // Line geometry; LINE_DEPTH must be a power of two so addresses wrap freely
  localparam int LINE_DEPTH  = 131072;
  localparam int CHANNELS    = 2;
  localparam int IO_CHANNELS = 2;
  localparam int ADDR_W      = $clog2(LINE_DEPTH);

  // Field widths
  localparam int SAMPLE_W  = 24;
  localparam int DELAY_W   = 17;
  localparam int FB_W      = 16;
  localparam int MIX_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;

  // Arithmetic widths
  localparam int FB_PROD_W  = SAMPLE_W + FB_W + 1;
  localparam int MIX_PROD_W = SAMPLE_W + MIX_W + 1;
  localparam int WET_SUM_W  = MIX_PROD_W + 1;
  localparam int STORE_W    = SAMPLE_W + 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd3;

  // Reset values
  localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd24000;
  localparam logic [MIX_W-1:0]   MIX_RESET   = 17'd32768;

  // Gain limits (0.92 in Q0.16, and unity)
  localparam logic [FB_W-1:0]  FB_CAP = 16'd60293;
  localparam logic [MIX_W-1:0] UNITY  = 17'd65536;

  // Half an LSB of a Q0.16 scale
  localparam int ROUND_HALF = 32768;
  localparam int Q_SHIFT    = 16;

  localparam logic signed [WET_SUM_W-1:0] S24_MAX = 43'sd8388607;
  localparam logic signed [WET_SUM_W-1:0] S24_MIN = -43'sd8388608;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } fed_in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } fed_out_t;

  // Effective gains, shared by all lanes
  typedef struct packed {
    logic             enabled;
    logic [FB_W-1:0]  fb;
    logic [MIX_W-1:0] wet;
    logic [MIX_W-1:0] dry;
  } gain_t;

  // Pipeline control from the sequencer to the lanes
  typedef struct packed {
    logic              advance;
    logic              acc;
    logic [ADDR_W-1:0] rd_addr;
    logic              s1_fwd;
    logic              s1_filled;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } lane_ctl_t;

  // Saturate a wide signed value to 24 bits
  function automatic sample_t sat24(logic signed [WET_SUM_W-1:0] v);
    sample_t r;
    if (v > S24_MAX) begin
      r = sample_t'(S24_MAX);
    end else if (v < S24_MIN) begin
      r = sample_t'(S24_MIN);
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/feedback_echo_delay.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Stereo feedback echo with one circular delay line per channel.
// ----------------------------------------------------------------------------
// Takes one stereo word per clock while the output is not held back and
// returns its result through memory read, gain multiply, round and
// write-back, and the output register. When the delay is 1 modulo the line
// depth, each frame feeds the very next one through the feedback multiplier,
// so a word then waits while the word ahead is in the first stage. Each channel
// has its own lane with a 131072 x 24 delay line RAM. After reset no clearing
// pass is needed: the write position and a wrap flag tell which line entries
// have been written, and unwritten entries read as silence.
// When disabled, words pass through unchanged and the lines are untouched.
// Write the configuration only while no word is in flight.
// ----------------------------------------------------------------------------
module feedback_echo_delay
  import fed_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fed_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fed_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic               enabled;
  logic [DELAY_W-1:0] delay_samples;
  logic [FB_W-1:0]    feedback_gain;
  logic [MIX_W-1:0]   mix_level;
  logic [MIX_W-1:0]   mix_cap;

  gain_t     gain;
  lane_ctl_t ctl;
  logic      advance;
  logic      s2_valid;
  sample_t   x [IO_CHANNELS];
  sample_t   y [IO_CHANNELS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b0;
      delay_samples <= DELAY_RESET;
      feedback_gain <= '0;
      mix_level     <= MIX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLED:  enabled       <= cfg_data[0];
        REG_DELAY:    delay_samples <= cfg_data[DELAY_W-1:0];
        REG_FEEDBACK: feedback_gain <= cfg_data[FB_W-1:0];
        REG_MIX:      mix_level     <= cfg_data[MIX_W-1:0];
        default:      ;
      endcase
    end
  end

  // Clamp gains
  assign mix_cap      = (mix_level > UNITY) ? UNITY : mix_level;
  assign gain.enabled = enabled;
  assign gain.fb      = (feedback_gain > FB_CAP) ? FB_CAP : feedback_gain;
  assign gain.wet     = mix_cap;
  assign gain.dry     = UNITY - mix_cap;

  assign x[0] = in_data.left_in;
  assign x[1] = in_data.right_in;

  fed_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .enabled       (enabled),
    .delay_samples (delay_samples),
    .advance       (advance),
    .s2_valid      (s2_valid),
    .ctl           (ctl)
  );

  // One lane per echoed channel; the rest ride along unchanged
  for (genvar c = 0; c < IO_CHANNELS; c++) begin : g_ch
    if (c < CHANNELS) begin : g_lane
      fed_lane u_lane (
        .clk  (clk),
        .ctl  (ctl),
        .gain (gain),
        .x    (x[c]),
        .y    (y[c])
      );
    end else begin : g_bypass
      sample_t x1;
      sample_t x2;
      always_ff @(posedge clk) begin
        if (ctl.acc) begin
          x1 <= x[c];
        end
        if (ctl.advance) begin
          x2 <= x1;
        end
      end
      assign y[c] = x2;
    end
  end

  fed_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .s2_valid  (s2_valid),
    .y         (y),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/fed_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_ctrl
// Write position, read addressing, fill tracking and hazard control shared by
// all echo lanes.
// ----------------------------------------------------------------------------
module fed_ctrl
  import fed_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               enabled,
  input  logic [DELAY_W-1:0] delay_samples,
  input  logic               advance,
  output logic               s2_valid,
  output lane_ctl_t          ctl
);

  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] rd_new;
  logic [ADDR_W-1:0] s1_wp;
  logic [ADDR_W-1:0] s1_rd;
  logic [ADDR_W-1:0] s2_wp;
  logic [ADDR_W-1:0] lw_addr;
  logic              wrapped;
  logic              s1_valid;
  logic              s1_filled;
  logic              lw_valid;
  logic              hazard;
  logic              acc;
  logic              wr_en;

  // Read address of the incoming word
  assign rd_new = wp - ADDR_W'(delay_samples);

  // Hold off a word whose tap is the write of the word right ahead of it
  assign hazard   = enabled && s1_valid && (s1_wp == rd_new);
  assign in_ready = advance && !hazard;
  assign acc      = in_valid && in_ready;
  assign wr_en    = advance && s2_valid && enabled;

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      wp       <= '0;
      wrapped  <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      if (advance) begin
        s1_valid <= acc;
        s2_valid <= s1_valid;
      end
      if (acc && enabled) begin
        wp <= wp + 1'b1;
        if (wp == ADDR_W'(LINE_DEPTH - 1)) begin
          wrapped <= 1'b1;
        end
      end
      if (wr_en) begin
        lw_valid <= 1'b1;
      end
    end
  end

  // Carry addresses down the pipe
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_wp     <= wp;
      s1_rd     <= rd_new;
      s1_filled <= wrapped || (rd_new < wp);
    end
    if (advance) begin
      s2_wp <= s1_wp;
    end
    if (wr_en) begin
      lw_addr <= s2_wp;
    end
  end

  assign ctl.advance   = advance;
  assign ctl.acc       = acc;
  assign ctl.rd_addr   = rd_new;
  assign ctl.s1_fwd    = lw_valid && (lw_addr == s1_rd);
  assign ctl.s1_filled = s1_filled;
  assign ctl.wr_en     = wr_en;
  assign ctl.wr_addr   = s2_wp;

endmodule

@@ rtl/fed_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_lane
// One channel of the echo: its delay line memory, the gain products and the
// rounding, saturation and write-back.
// ----------------------------------------------------------------------------
module fed_lane
  import fed_pkg::*;
(
  input  logic      clk,
  input  lane_ctl_t ctl,
  input  gain_t     gain,
  input  sample_t   x,
  output sample_t   y
);

  sample_t mem [LINE_DEPTH];

  sample_t rdata;
  sample_t s1_x;
  sample_t s2_x;
  sample_t delayed;
  sample_t lw_data;
  sample_t stored;

  logic signed [FB_PROD_W-1:0]  p_fb;
  logic signed [MIX_PROD_W-1:0] p_dry;
  logic signed [MIX_PROD_W-1:0] p_wet;
  logic signed [FB_PROD_W-1:0]  fb_round;
  logic signed [STORE_W-1:0]    store_sum;
  logic signed [WET_SUM_W-1:0]  wet_sum;
  logic signed [WET_SUM_W-1:0]  wet_round;

  // Read the tap as the word enters
  always_ff @(posedge clk) begin
    if (ctl.acc) begin
      rdata <= mem[ctl.rd_addr];
      s1_x  <= x;
    end
  end

  // Pick the tap: last write, memory word, or silence for a never-written entry
  always_comb begin
    if (ctl.s1_fwd) begin
      delayed = lw_data;
    end else if (ctl.s1_filled) begin
      delayed = rdata;
    end else begin
      delayed = '0;
    end
  end

  // Form the gain products
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      p_fb  <= delayed * $signed({1'b0, gain.fb});
      p_dry <= s1_x * $signed({1'b0, gain.dry});
      p_wet <= delayed * $signed({1'b0, gain.wet});
      s2_x  <= s1_x;
    end
  end

  // Round, add and saturate
  always_comb begin
    fb_round  = (p_fb + FB_PROD_W'(ROUND_HALF)) >>> Q_SHIFT;
    store_sum = STORE_W'(s2_x) + STORE_W'(fb_round[STORE_W-1:0]);
    stored    = sat24(WET_SUM_W'(store_sum));
    wet_sum   = WET_SUM_W'(p_dry) + WET_SUM_W'(p_wet) + WET_SUM_W'(ROUND_HALF);
    wet_round = wet_sum >>> Q_SHIFT;
  end

  assign y = gain.enabled ? sat24(wet_round) : s2_x;

  // Write back and keep the last write for the tap bypass
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= stored;
      lw_data          <= stored;
    end
  end

endmodule

@@ rtl/fed_merge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fed_merge
// Output register: gathers the lane results into one output word and holds
// it until taken.
// ----------------------------------------------------------------------------
module fed_merge
  import fed_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s2_valid,
  input  sample_t  y [IO_CHANNELS],
  output logic     advance,
  output logic     out_valid,
  input  logic     out_ready,
  output fed_out_t out_data
);

  // Move the pipe whenever the output register is free or being emptied
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      out_data.left_out  <= y[0];
      out_data.right_out <= y[1];
    end
  end

endmodule
